FILE: rtl/page_free_list_allocator_macros.svh
// Assertion macros shared by the page free list allocator RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property check, sampled on clk_i and disabled during reset.
`define PFLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("page free list allocator: assertion failed");
// Same-cycle implication check.
`define PFLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page free list allocator: implication failed");
// Next-cycle implication check.
`define PFLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page free list allocator: next-cycle implication failed");
`else
`define PFLA_ASSERT(lbl, prop)
`define PFLA_ASSERT_IMP(lbl, ante, cons)
`define PFLA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/pfla_pkg.sv
// Package for the page free list allocator: payload structs, codes and
// the command/status structs between controller and datapath. No dependencies.
package pfla_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned PhysTopW = 27;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [AddrW-1:0]    VirtBaseRst  = 32'h8000_0000;
  localparam logic [PhysTopW-1:0] PhysTopRst   = 27'h400_0000;
  localparam logic [AddrW-1:0]    KernelEndRst = 32'h8000_0000;

  // Request type codes.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_VIRT_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHYS_TOP   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KERNEL_END = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_TOP   = 3'd2;
  localparam logic [2:0] ST_LOW   = 3'd3;
  localparam logic [2:0] ST_ALIGN = 3'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] page_addr;
    logic [AddrW-1:0] range_end;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] alloc_addr;
    logic [2:0]       status;
  } rsp_t;

  typedef struct packed {
    logic       load;      // latch the request fields
    logic       pop;       // head takes the link read of the old head
    logic       push;      // write link of current page, head takes its index
    logic       finish;    // register the result and raise the strobe
    logic       ret_addr;  // result carries the allocated address
    logic [2:0] code;      // result status
  } ctrl_cmd_t;

  typedef struct packed {
    logic       empty;       // list holds nothing
    logic       chk_fail;    // current page fails a free check
    logic [2:0] chk_code;    // status of the first failing check
    logic       range_more;  // another page fits below the range end
  } dp_status_t;

endpackage

FILE: rtl/pfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfla_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pfla_datapath.sv
// Datapath of the page free list allocator: configuration registers, head
// register, link memory, page checks and result register. Uses pfla_pkg, pfla_ram.
module pfla_datapath
  import pfla_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned NUM_PAGES  = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  input  req_t               req_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         stat_o,
  output logic               done_o,
  output rsp_t               result_o
);

  localparam int unsigned OffW = $clog2(PAGE_BYTES);
  localparam int unsigned IdxW = $clog2(NUM_PAGES + 1);
  localparam int unsigned RamAw = $clog2(NUM_PAGES);

  logic [AddrW-1:0]    virt_base_q, kernel_end_q;
  logic [PhysTopW-1:0] phys_top_q;
  logic [IdxW-1:0]     head_q, head_d;
  logic [AddrW-1:0]    page_q, page_d;
  logic [AddrW-1:0]    rend_q, rend_d;
  logic                done_q;
  rsp_t                result_q, result_d;

  logic [AddrW-1:0] phys;
  logic [AddrW-1:0] phys_pg;
  logic [IdxW-1:0]  push_idx;
  logic [IdxW-1:0]  link_rdata;
  logic [AddrW-1:0] alloc_va;
  logic [AddrW:0]   page_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      virt_base_q  <= VirtBaseRst;
      phys_top_q   <= PhysTopRst;
      kernel_end_q <= KernelEndRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VIRT_BASE:  virt_base_q  <= cfg_data_i;
        CFG_PHYS_TOP:   phys_top_q   <= cfg_data_i[PhysTopW-1:0];
        CFG_KERNEL_END: kernel_end_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign page_next = {1'b0, page_q} + (AddrW + 1)'(PAGE_BYTES);
  assign alloc_va  = (AddrW'(head_q) << OffW) + virt_base_q;

  // Page checks, in the order the status codes take precedence.
  always_comb begin
    phys     = page_q - virt_base_q;
    phys_pg  = phys >> OffW;
    push_idx = phys_pg[IdxW-1:0];
    stat_o.empty      = head_q >= IdxW'(NUM_PAGES);
    stat_o.range_more = page_next <= {1'b0, rend_q};
    stat_o.chk_fail = 1'b1;
    stat_o.chk_code = ST_OK;
    if (phys >= {{(AddrW - PhysTopW){1'b0}}, phys_top_q}) begin
      stat_o.chk_code = ST_TOP;
    end else if (page_q < kernel_end_q) begin
      stat_o.chk_code = ST_LOW;
    end else if (page_q[OffW-1:0] != '0) begin
      stat_o.chk_code = ST_ALIGN;
    end else if (phys_pg >= AddrW'(NUM_PAGES)) begin
      stat_o.chk_code = ST_TOP;
    end else begin
      stat_o.chk_fail = 1'b0;
    end
  end

  pfla_ram #(
    .WIDTH (IdxW),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (push_idx[RamAw-1:0]),
    .wdata_i (head_q),
    .raddr_i (head_q[RamAw-1:0]),
    .rdata_o (link_rdata)
  );

  always_comb begin
    head_d   = head_q;
    page_d   = page_q;
    rend_d   = rend_q;
    result_d = result_q;
    if (cmd_i.load) begin
      page_d = req_i.page_addr;
      rend_d = req_i.range_end;
    end
    if (cmd_i.push) begin
      head_d = push_idx;
      page_d = page_next[AddrW-1:0];
    end else if (cmd_i.pop) begin
      head_d = link_rdata;
    end
    if (cmd_i.finish) begin
      result_d.alloc_addr = cmd_i.ret_addr ? alloc_va : '0;
      result_d.status     = cmd_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= IdxW'(NUM_PAGES);
      done_q <= 1'b0;
    end else begin
      head_q <= head_d;
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    rend_q   <= rend_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: rtl/pfla_ctrl.sv
// Controller of the page free list allocator: sequences allocation, single
// free and range free over the datapath. Uses pfla_pkg.
module pfla_ctrl
  import pfla_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] req_type_i,
  input  dp_status_t stat_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_FREE  = 5'b00100,
    S_RANGE = 5'b01000,
    S_NOP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (req_type_i)
            REQ_ALLOC: state_d = S_ALLOC;
            REQ_FREE:  state_d = S_FREE;
            REQ_RANGE: state_d = S_RANGE;
            default:   state_d = S_NOP;
          endcase
        end
      end
      S_ALLOC: begin
        cmd_o.finish = 1'b1;
        if (stat_i.empty) begin
          cmd_o.code = ST_EMPTY;
        end else begin
          cmd_o.pop      = 1'b1;
          cmd_o.ret_addr = 1'b1;
          cmd_o.code     = ST_OK;
        end
        state_d = S_IDLE;
      end
      S_FREE: begin
        cmd_o.finish = 1'b1;
        if (stat_i.chk_fail) begin
          cmd_o.code = stat_i.chk_code;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.code = ST_OK;
        end
        state_d = S_IDLE;
      end
      S_RANGE: begin
        if (!stat_i.range_more) begin
          cmd_o.finish = 1'b1;
          cmd_o.code   = ST_OK;
          state_d      = S_IDLE;
        end else if (stat_i.chk_fail) begin
          cmd_o.finish = 1'b1;
          cmd_o.code   = stat_i.chk_code;
          state_d      = S_IDLE;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      S_NOP: begin
        cmd_o.finish = 1'b1;
        cmd_o.code   = ST_OK;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

FILE: rtl/page_free_list_allocator.sv
// Page free list allocator, top level: LIFO free list of page frames.
// Uses pfla_pkg, pfla_ctrl, pfla_datapath and the assertion macros header.
//
// Usage. A request is transferred at a rising edge where start_i is high and
// busy_o is low; req_i carries the request type, page address and range end.
// Every request produces exactly one result: done_o is high for one cycle and
// result_o holds the allocated virtual address (zero unless an allocation
// succeeded) and the status. The receiver cannot stall; done_o never waits.
// Configuration registers (virtual base, physical top, kernel end) are
// written through cfg_valid_i/cfg_index_i/cfg_data_i, always ready; a write
// to an index beyond the three registers is dropped. Write them while idle.
//
// Timing. The cycle after the request transfer does the work: an allocation
// uses the link memory read issued at the transfer edge and moves the head,
// a single free checks the page and writes one link. The result is
// registered in result_q and done_q, so done_o rises after the work is done;
// busy_o is already low while done_o is high, so a new allocation or single
// free can be taken while the result is shown. A range free writes one link
// per pushed page through the single memory write port, and finishes when
// no further page fits below the range end or a page fails a check.
// Reset empties the list at once; the link memory needs no clearing, since
// an entry is read only after a push has written it.
`include "page_free_list_allocator_macros.svh"

module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned NUM_PAGES  = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  req_t               req_i,
  output logic               done_o,
  output rsp_t               result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;
  logic       ctrl_busy;

  // The controller only looks at start while idle, so gating is implicit.
  pfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_i.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (ctrl_busy)
  );

  pfla_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .NUM_PAGES  (NUM_PAGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  assign busy_o      = ctrl_busy;
  assign cfg_ready_o = 1'b1;

  // A transfer always starts work in the next cycle.
  `PFLA_ASSERT_NXT(a_start_busy, start_i && !busy_o, busy_o)
  // A result only follows a cycle of work.
  `PFLA_ASSERT_IMP(a_done_after_busy, done_o, $past(busy_o))
  // A failed allocation returns address zero.
  `PFLA_ASSERT_IMP(a_empty_addr_zero, done_o && result_o.status == ST_EMPTY,
                   result_o.alloc_addr == '0)
  // Strobes never come back to back: each item returns to idle before the next can finish.
  `PFLA_ASSERT_NXT(a_done_single, done_o, !done_o)

endmodule
